>>> src/pga_pkg.sv
// ----------------------------------------------------------------------------
// pga_pkg: shared widths and types of the pairwise gravity unit
// Fixed-point formats, lane count and the side payload that travels along
// the square-root, multiply and divide pipelines.
// ----------------------------------------------------------------------------
package pga_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32;
   localparam int MASS_W    = 32;
   localparam int ACC_W     = 32;
   localparam int D_W       = POS_W + 1;
   localparam int MAG_W     = POS_W;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int S_W       = SQ_W + 2;
   localparam int R_W       = S_W / 2;
   localparam int DEN_W     = S_W + R_W;
   localparam int PROD_W    = MASS_W + MAG_W;
   localparam int NUM_W     = PROD_W + 2 * FRAC_BITS;
   localparam int QB        = ACC_W;
   localparam int NLANE     = 6;
   localparam int NAXIS     = 3;

   // s * r is split into partial products of at most 22 x 17 bits
   localparam int SC_W = 22;
   localparam int SC_N = S_W / SC_W;
   localparam int RL_W = 17;
   localparam int RH_W = R_W - RL_W;
   localparam int PP_W = SC_W + RL_W;
   localparam int PART_W = SC_W + R_W;

   typedef struct packed {
      logic                          skip;
      logic [NLANE-1:0]              neg;
      logic [NLANE-1:0][NUM_W-1:0]   num;
   } side_type;

endpackage

>>> src/pga_isqrt.sv
// ----------------------------------------------------------------------------
// pga_isqrt: pipelined integer square root
// One result bit per stage, restoring digit-by-digit form on the remainder.
// ----------------------------------------------------------------------------
module pga_isqrt
   import pga_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [S_W-1:0]   in_s,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [S_W-1:0]   out_s,
   output logic [R_W-1:0]   out_r,
   output side_type         out_side
);

   localparam int TW = S_W + 2;

   logic             v_ff    [R_W];
   logic [S_W-1:0]   rem_ff  [R_W];
   logic [R_W-1:0]   res_ff  [R_W];
   logic [S_W-1:0]   s_ff    [R_W];
   side_type         side_ff [R_W];

   for (genvar k = 0; k < R_W; k++) begin : g_st
      localparam int B = R_W - 1 - k;
      logic             v_src;
      logic [S_W-1:0]   rem_src;
      logic [R_W-1:0]   res_src;
      logic [S_W-1:0]   s_src;
      side_type         side_src;
      logic [TW-1:0]    trial;
      logic             ge;
      logic [S_W-1:0]   rem_in;
      logic [R_W-1:0]   res_in;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = in_s;
         assign res_src  = '0;
         assign s_src    = in_s;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign res_src  = res_ff[k-1];
         assign s_src    = s_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         // (res + 2^B)^2 - res^2
         trial  = (TW'(res_src) << (B + 1)) + (TW'(1) << (2 * B));
         ge     = TW'(rem_src) >= trial;
         rem_in = ge ? S_W'(TW'(rem_src) - trial) : rem_src;
         res_in = ge ? (res_src | (R_W'(1) << B)) : res_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            res_ff[k]  <= res_in;
            s_ff[k]    <= s_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[R_W-1];
   assign out_s     = s_ff[R_W-1];
   assign out_r     = res_ff[R_W-1];
   assign out_side  = side_ff[R_W-1];

endmodule

>>> src/pga_den_mul.sv
// ----------------------------------------------------------------------------
// pga_den_mul: three-stage s * r multiplier
// Partial products, then per-chunk sums, then the final weighted sum.
// ----------------------------------------------------------------------------
module pga_den_mul
   import pga_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [S_W-1:0]     in_s,
   input  logic [R_W-1:0]     in_r,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [DEN_W-1:0]   out_den,
   output side_type           out_side
);

   logic                v1_ff, v2_ff, v3_ff;
   logic [PP_W-1:0]     plo_ff  [SC_N];
   logic [PP_W-1:0]     phi_ff  [SC_N];
   logic [PART_W-1:0]   part_ff [SC_N];
   logic [DEN_W-1:0]    den_ff;
   side_type            side1_ff, side2_ff, side3_ff;
   logic [DEN_W-1:0]    den_in;

   always_comb begin
      den_in = '0;
      for (int i = 0; i < SC_N; i++) begin
         den_in = den_in + (DEN_W'(part_ff[i]) << (SC_W * i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < SC_N; i++) begin
            plo_ff[i]  <= PP_W'(in_s[SC_W*i +: SC_W] * in_r[RL_W-1:0]);
            phi_ff[i]  <= PP_W'(in_s[SC_W*i +: SC_W] * in_r[R_W-1:RL_W]);
            part_ff[i] <= PART_W'(plo_ff[i]) + (PART_W'(phi_ff[i]) << RL_W);
         end
         den_ff   <= den_in;
         side1_ff <= in_side;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_den   = den_ff;
   assign out_side  = side3_ff;

endmodule

>>> src/pga_div.sv
// ----------------------------------------------------------------------------
// pga_div: six-lane pipelined restoring divider with saturation
// One quotient bit per stage for all lanes against a shared divisor.
// ----------------------------------------------------------------------------
module pga_div
   import pga_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [DEN_W-1:0]              in_den,
   input  side_type                      in_side,
   output logic                          out_valid,
   output logic [NLANE-1:0][ACC_W-1:0]   out_acc,
   output logic                          out_skip
);

   localparam int CW = DEN_W + QB + 1;

   logic                          v_ff    [QB];
   logic [DEN_W-1:0]              den_ff  [QB];
   logic                          skip_ff [QB];
   logic [NLANE-1:0]              neg_ff  [QB];
   logic [NLANE-1:0]              ovf_ff  [QB];
   logic [NLANE-1:0][NUM_W-1:0]   rem_ff  [QB];
   logic [NLANE-1:0][QB-1:0]      q_ff    [QB];

   for (genvar k = 0; k < QB; k++) begin : g_st
      localparam int I = QB - 1 - k;
      logic                          v_src;
      logic [DEN_W-1:0]              den_src;
      logic                          skip_src;
      logic [NLANE-1:0]              neg_src;
      logic [NLANE-1:0]              ovf_src;
      logic [NLANE-1:0][NUM_W-1:0]   rem_src;
      logic [NLANE-1:0][QB-1:0]      q_src;
      logic [NLANE-1:0]              ovf_in;
      logic [NLANE-1:0][NUM_W-1:0]   rem_in;
      logic [NLANE-1:0][QB-1:0]      q_in;
      logic [CW-1:0]                 sub;
      logic [CW-1:0]                 top;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign den_src  = in_den;
         assign skip_src = in_side.skip;
         assign neg_src  = in_side.neg;
         assign ovf_src  = '0;
         assign rem_src  = in_side.num;
         assign q_src    = '0;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign skip_src = skip_ff[k-1];
         assign neg_src  = neg_ff[k-1];
         assign ovf_src  = ovf_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign q_src    = q_ff[k-1];
      end

      always_comb begin
         sub = CW'(den_src) << I;
         top = CW'(den_src) << QB;
         for (int n = 0; n < NLANE; n++) begin
            // a quotient of 2^QB or more saturates whatever its sign
            ovf_in[n] = ovf_src[n] | ((k == 0) && (CW'(rem_src[n]) >= top));
            if (CW'(rem_src[n]) >= sub) begin
               rem_in[n] = NUM_W'(CW'(rem_src[n]) - sub);
               q_in[n]   = q_src[n] | (QB'(1) << I);
            end else begin
               rem_in[n] = rem_src[n];
               q_in[n]   = q_src[n];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k]  <= den_src;
            skip_ff[k] <= skip_src;
            neg_ff[k]  <= neg_src;
            ovf_ff[k]  <= ovf_in;
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= q_in;
         end
      end
   end

   // clamp to the signed range and apply the lane sign; a skipped pair gives zero in all lanes
   always_comb begin
      logic [ACC_W-1:0] lim;
      logic [ACC_W-1:0] mag;
      for (int n = 0; n < NLANE; n++) begin
         lim = neg_ff[QB-1][n] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
         mag = (ovf_ff[QB-1][n] || (q_ff[QB-1][n] > lim)) ? lim : q_ff[QB-1][n];
         if (skip_ff[QB-1]) begin
            out_acc[n] = '0;
         end else if (neg_ff[QB-1][n]) begin
            out_acc[n] = ACC_W'(0) - mag;
         end else begin
            out_acc[n] = mag;
         end
      end
   end

   assign out_valid = v_ff[QB-1];
   assign out_skip  = skip_ff[QB-1];

endmodule

>>> src/pairwise_gravity_acceleration_unit.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_acceleration_unit: direct pairwise gravity increments
// Path: stages f1 to f3, square root, s * r multiplier, divider, then the output register to rsp_tvalid.
// Throughput: one pair per cycle, limited by nothing but the single-word skid.
// Depth is set by the 33-stage square root and the 32-stage divider.
// Reset: synchronous, active high; clears all valid bits, the output and skid valids included.
// ----------------------------------------------------------------------------
module pairwise_gravity_acceleration_unit
   import pga_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, mass_a, mass_b
   input  logic [255:0]   req_tdata,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // dacc_a_x, dacc_a_y, dacc_a_z, dacc_b_x, dacc_b_y, dacc_b_z
   output logic [191:0]   rsp_tdata,
   // skipped
   output logic [0:0]     rsp_tuser
);

   logic           out_v_ff, skid_v_ff;

   // Whole pipeline advances unless the skid holds a word.
   logic en;
   assign en         = !skid_v_ff;
   assign req_tready = en;

   // ---- stage f1: difference vector, magnitudes and signs
   logic               v1_ff;
   logic [MAG_W-1:0]   mag1_ff [NAXIS];
   logic [NAXIS-1:0]   neg1_ff;
   logic [MASS_W-1:0]  ma1_ff, mb1_ff;

   // ---- stage f2: squares and mass products
   logic               v2_ff;
   logic [SQ_W-1:0]    sq2_ff   [NAXIS];
   logic [PROD_W-1:0]  prod2_ff [NLANE];
   logic [NAXIS-1:0]   neg2_ff;

   // ---- stage f3: sum of squares and side payload
   logic               v3_ff;
   logic [S_W-1:0]     s3_ff;
   side_type           side3_ff;
   logic [S_W-1:0]     s3_in;
   side_type           side3_in;

   logic [D_W-1:0]     d1_in   [NAXIS];
   logic [MAG_W-1:0]   mag1_in [NAXIS];

   always_comb begin
      for (int i = 0; i < NAXIS; i++) begin
         d1_in[i] = {req_tdata[POS_W*(NAXIS+i) + POS_W-1], req_tdata[POS_W*(NAXIS+i) +: POS_W]}
                  - {req_tdata[POS_W*i + POS_W-1], req_tdata[POS_W*i +: POS_W]};
         mag1_in[i] = d1_in[i][D_W-1] ? MAG_W'(D_W'(0) - d1_in[i]) : d1_in[i][MAG_W-1:0];
      end
   end

   always_comb begin
      s3_in = '0;
      for (int i = 0; i < NAXIS; i++) begin
         s3_in = s3_in + S_W'(sq2_ff[i]);
      end
      side3_in.skip = (s3_in == '0);
      // lanes 0..2 act on body a (toward b), lanes 3..5 on body b (toward a)
      for (int n = 0; n < NLANE; n++) begin
         side3_in.num[n] = NUM_W'(prod2_ff[n]) << (2 * FRAC_BITS);
      end
      side3_in.neg = {~neg2_ff, neg2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NAXIS; i++) begin
            mag1_ff[i] <= mag1_in[i];
            neg1_ff[i] <= d1_in[i][D_W-1];
            sq2_ff[i]  <= SQ_W'(mag1_ff[i] * mag1_ff[i]);
            prod2_ff[i]         <= PROD_W'(mb1_ff * mag1_ff[i]);
            prod2_ff[NAXIS + i] <= PROD_W'(ma1_ff * mag1_ff[i]);
         end
         ma1_ff   <= req_tdata[POS_W*2*NAXIS +: MASS_W];
         mb1_ff   <= req_tdata[POS_W*2*NAXIS + MASS_W +: MASS_W];
         neg2_ff  <= neg1_ff;
         s3_ff    <= s3_in;
         side3_ff <= side3_in;
      end
   end

   // ---- square root, denominator s * r, divide
   logic               sq_v;
   logic [S_W-1:0]     sq_s;
   logic [R_W-1:0]     sq_r;
   side_type           sq_side;
   logic               mul_v;
   logic [DEN_W-1:0]   mul_den;
   side_type           mul_side;
   logic               div_v;
   logic [NLANE-1:0][ACC_W-1:0] div_acc;
   logic               div_skip;

   pga_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_s      (s3_ff),
      .in_side   (side3_ff),
      .out_valid (sq_v),
      .out_s     (sq_s),
      .out_r     (sq_r),
      .out_side  (sq_side)
   );

   pga_den_mul u_den_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v),
      .in_s      (sq_s),
      .in_r      (sq_r),
      .in_side   (sq_side),
      .out_valid (mul_v),
      .out_den   (mul_den),
      .out_side  (mul_side)
   );

   pga_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mul_v),
      .in_den    (mul_den),
      .in_side   (mul_side),
      .out_valid (div_v),
      .out_acc   (div_acc),
      .out_skip  (div_skip)
   );

   // ---- output word and skid: hold a word while the sink stalls
   logic [191:0]   out_data_ff, skid_data_ff;
   logic           out_skip_ff, skid_skip_ff;
   logic           take;

   assign take = en && div_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= take;
         end
      end else if (take) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_data_ff <= skid_data_ff;
            out_skip_ff <= skid_skip_ff;
         end else begin
            out_data_ff <= div_acc;
            out_skip_ff <= div_skip;
         end
      end else if (take) begin
         skid_data_ff <= div_acc;
         skid_skip_ff <= div_skip;
      end
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_skip_ff;

endmodule
